### design/joystick_deadzone_direction_keys_macros.svh
// ----------------------------------------------------------------------------
// Joystick direction keys assertion macros
// Shared concurrent assertion forms for the joystick direction key block.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DEADZONE_DIRECTION_KEYS_MACROS_SVH
`define JOYSTICK_DEADZONE_DIRECTION_KEYS_MACROS_SVH

// same-cycle implication
`define JDK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define JDK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### design/jdk_pkg.sv
// ----------------------------------------------------------------------------
// Joystick direction keys package
// Codes, transaction types and small helper functions for the block.
// ----------------------------------------------------------------------------
package jdk_pkg;

   typedef enum logic [1:0] {
      CSR_RADIUS    = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_ORIENT    = 2'd2,
      CSR_MODE      = 2'd3
   } csr_index_type;

   localparam logic [1:0] KIND_ANALOG  = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam logic [1:0] KEY_UP    = 2'd0;
   localparam logic [1:0] KEY_LEFT  = 2'd1;
   localparam logic [1:0] KEY_DOWN  = 2'd2;
   localparam logic [1:0] KEY_RIGHT = 2'd3;

   localparam logic [1:0] ORIENT_UP    = 2'd0;
   localparam logic [1:0] ORIENT_LEFT  = 2'd1;
   localparam logic [1:0] ORIENT_DOWN  = 2'd2;
   localparam logic [1:0] ORIENT_RIGHT = 2'd3;

   localparam logic [1:0] MODE_ANALOG = 2'd0;
   localparam logic [1:0] MODE_LETTER = 2'd1;
   localparam logic [1:0] MODE_ARROW  = 2'd2;

   localparam logic [6:0] RADIUS_RESET    = 7'd0;
   localparam logic [6:0] THRESHOLD_RESET = 7'd64;
   localparam logic [1:0] ORIENT_RESET    = ORIENT_UP;
   localparam logic [1:0] MODE_RESET      = MODE_ARROW;

   localparam int MAX_EVENTS = 4;

   typedef enum logic [1:0] {
      LVL_NEUTRAL = 2'd0,
      LVL_POS     = 2'd1,
      LVL_NEG     = 2'd2
   } level_type;

   typedef struct packed {
      logic [6:0] radius;
      logic [6:0] threshold;
      logic [1:0] orient;
      logic [1:0] mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        key;
      logic              key_set;
      logic signed [7:0] axis_x;
      logic signed [7:0] axis_y;
   } event_type;

   typedef struct packed {
      logic [2:0]                       count;
      event_type [MAX_EVENTS-1:0]       evs;
      level_type                        v_level;
      level_type                        h_level;
   } batch_type;

   function automatic logic signed [7:0] neg_sat(input logic signed [7:0] v);
      return (v == 8'sh80) ? 8'sh7F : (8'sd0 - v);
   endfunction

   function automatic level_type classify(input logic signed [7:0] v,
                                          input logic [6:0] thr);
      logic signed [8:0] v9;
      logic signed [8:0] t9;
      v9 = {v[7], v};
      t9 = {2'b00, thr};
      if (v9 > t9) return LVL_POS;
      if (v9 < -t9) return LVL_NEG;
      return LVL_NEUTRAL;
   endfunction

endpackage

### design/jdk_if.sv
// ----------------------------------------------------------------------------
// Joystick direction keys channels
// Valid/ready channels for sample transactions and result transactions.
// ----------------------------------------------------------------------------
interface jdk_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] x_sample;
   logic signed [7:0] y_sample;

   modport source (output valid, output x_sample, output y_sample, input ready);
   modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

interface jdk_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [1:0]        key;
   logic              key_set;
   logic signed [7:0] axis_x;
   logic signed [7:0] axis_y;
   logic              last;

   modport source (output valid, output kind, output key, output key_set,
                   output axis_x, output axis_y, output last, input ready);
   modport sink (input valid, input kind, input key, input key_set,
                 input axis_x, input axis_y, input last, output ready);
endinterface

### design/jdk_event_gen.sv
// ----------------------------------------------------------------------------
// Joystick direction keys event generator
// Deadzone, rotation, axis classification and key or analog event list for one sample.
// ----------------------------------------------------------------------------
module jdk_event_gen import jdk_pkg::*; (
   input  logic signed [7:0] x_sample,
   input  logic signed [7:0] y_sample,
   input  cfg_type           cfg,
   input  level_type         v_level,
   input  level_type         h_level,
   output batch_type         batch
);

   logic signed [15:0] xe;
   logic signed [15:0] ye;
   logic signed [15:0] xsq;
   logic signed [15:0] ysq;
   logic        [15:0] r16;
   logic        [15:0] rsq;
   logic        [16:0] mag;
   logic               in_zone;
   logic signed [7:0]  dx;
   logic signed [7:0]  dy;
   logic signed [7:0]  rx;
   logic signed [7:0]  ry;
   level_type          vc;
   level_type          hc;
   logic               kset;

   assign xe      = {{8{x_sample[7]}}, x_sample};
   assign ye      = {{8{y_sample[7]}}, y_sample};
   assign xsq     = xe * xe;
   assign ysq     = ye * ye;
   assign r16     = {9'd0, cfg.radius};
   assign rsq     = r16 * r16;
   assign mag     = {1'b0, xsq} + {1'b0, ysq};
   assign in_zone = mag < {1'b0, rsq};
   assign dx      = in_zone ? 8'sd0 : x_sample;
   assign dy      = in_zone ? 8'sd0 : y_sample;
   assign kset    = (cfg.mode == MODE_ARROW);

   always_comb begin
      case (cfg.orient)
         ORIENT_LEFT: begin
            rx = neg_sat(dy);
            ry = dx;
         end
         ORIENT_DOWN: begin
            rx = neg_sat(dx);
            ry = neg_sat(dy);
         end
         ORIENT_RIGHT: begin
            rx = dy;
            ry = neg_sat(dx);
         end
         default: begin
            rx = dx;
            ry = dy;
         end
      endcase
   end

   assign vc = classify(ry, cfg.threshold);
   assign hc = classify(rx, cfg.threshold);

   always_comb begin
      logic [2:0] n;
      n       = 3'd0;
      batch   = '0;
      batch.v_level = v_level;
      batch.h_level = h_level;
      if (cfg.mode == MODE_ANALOG) begin
         batch.evs[0] = '{kind: KIND_ANALOG, key: KEY_UP, key_set: 1'b0,
                          axis_x: rx, axis_y: ry};
         n = 3'd1;
      end else if (cfg.mode == MODE_LETTER || cfg.mode == MODE_ARROW) begin
         if (v_level != vc) begin
            if (v_level != LVL_NEUTRAL) begin
               batch.evs[n[1:0]] = '{kind: KIND_RELEASE,
                                     key: (v_level == LVL_POS) ? KEY_UP : KEY_DOWN,
                                     key_set: kset, axis_x: 8'sd0, axis_y: 8'sd0};
               n = n + 3'd1;
            end
            if (vc != LVL_NEUTRAL) begin
               batch.evs[n[1:0]] = '{kind: KIND_PRESS,
                                     key: (vc == LVL_POS) ? KEY_UP : KEY_DOWN,
                                     key_set: kset, axis_x: 8'sd0, axis_y: 8'sd0};
               n = n + 3'd1;
            end
         end
         if (h_level != hc) begin
            if (h_level != LVL_NEUTRAL) begin
               batch.evs[n[1:0]] = '{kind: KIND_RELEASE,
                                     key: (h_level == LVL_POS) ? KEY_RIGHT : KEY_LEFT,
                                     key_set: kset, axis_x: 8'sd0, axis_y: 8'sd0};
               n = n + 3'd1;
            end
            if (hc != LVL_NEUTRAL) begin
               batch.evs[n[1:0]] = '{kind: KIND_PRESS,
                                     key: (hc == LVL_POS) ? KEY_RIGHT : KEY_LEFT,
                                     key_set: kset, axis_x: 8'sd0, axis_y: 8'sd0};
               n = n + 3'd1;
            end
         end
         if (n == 3'd0) begin
            batch.evs[0] = '{kind: KIND_NONE, key: KEY_UP, key_set: kset,
                             axis_x: 8'sd0, axis_y: 8'sd0};
            n = 3'd1;
         end
         batch.v_level = vc;
         batch.h_level = hc;
      end else begin
         batch.evs[0] = '{kind: KIND_NONE, key: KEY_UP, key_set: 1'b0,
                          axis_x: 8'sd0, axis_y: 8'sd0};
         n = 3'd1;
      end
      batch.count = n;
   end

endmodule

### design/joystick_deadzone_direction_keys.sv
// ----------------------------------------------------------------------------
// Joystick deadzone direction keys
// Radial deadzone, mounting rotation and direction key events per sample.
// ----------------------------------------------------------------------------
// A sample is registered on acceptance and expanded into its list of result
// transactions; the list enters the result buffer once that is empty or
// drains, and is sent one transaction per cycle while the receiver is ready,
// the final one flagged by last. Samples that yield one result (analog
// report or no action) stream at one per cycle while the receiver is ready;
// a sample that yields n key events (n up to 4) holds the single result port
// until all n are taken. The input register takes one further sample while
// the buffer drains and holds it until the last buffered result is taken.
`include "joystick_deadzone_direction_keys_macros.svh"

module joystick_deadzone_direction_keys import jdk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   jdk_req_if.sink           req_chan,
   jdk_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type           cfg_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic signed [7:0] x_ff;
   logic signed [7:0] y_ff;
   logic              buf_valid_ff;
   logic              buf_valid_in;
   batch_type         batch_ff;
   logic [1:0]        idx_ff;
   logic [1:0]        idx_in;
   level_type         v_level_ff;
   level_type         h_level_ff;
   batch_type         batch_next;
   csr_index_type     csr_sel;
   logic              csr_write;
   logic              req_fire;
   logic              rsp_fire;
   logic              rsp_is_last;
   logic              drain;
   logic              load;
   event_type         cur_ev;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius    <= RADIUS_RESET;
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.orient    <= ORIENT_RESET;
         cfg_ff.mode      <= MODE_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            CSR_RADIUS:    cfg_ff.radius    <= csr_pwdata[6:0];
            CSR_THRESHOLD: cfg_ff.threshold <= csr_pwdata[6:0];
            CSR_ORIENT:    cfg_ff.orient    <= csr_pwdata[1:0];
            CSR_MODE:      cfg_ff.mode      <= csr_pwdata[1:0];
            default:       cfg_ff           <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_RADIUS:    csr_prdata = {25'd0, cfg_ff.radius};
         CSR_THRESHOLD: csr_prdata = {25'd0, cfg_ff.threshold};
         CSR_ORIENT:    csr_prdata = {30'd0, cfg_ff.orient};
         CSR_MODE:      csr_prdata = {30'd0, cfg_ff.mode};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // handshake control
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign rsp_fire    = buf_valid_ff && rsp_chan.ready;
   assign rsp_is_last = ({1'b0, idx_ff} == (batch_ff.count - 3'd1));
   assign drain       = rsp_fire && rsp_is_last;
   assign load        = in_valid_ff && (!buf_valid_ff || drain);
   assign req_chan.ready = !in_valid_ff || load;

   assign in_valid_in  = req_fire ? 1'b1 : (load ? 1'b0 : in_valid_ff);
   assign buf_valid_in = load ? 1'b1 : (drain ? 1'b0 : buf_valid_ff);
   assign idx_in       = load ? 2'd0 : (rsp_fire ? idx_ff + 2'd1 : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         buf_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         v_level_ff   <= LVL_NEUTRAL;
         h_level_ff   <= LVL_NEUTRAL;
      end else begin
         in_valid_ff  <= in_valid_in;
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
         if (load) begin
            v_level_ff <= batch_next.v_level;
            h_level_ff <= batch_next.h_level;
         end
      end
   end

   // sample and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff <= req_chan.x_sample;
         y_ff <= req_chan.y_sample;
      end
      if (load) begin
         batch_ff <= batch_next;
      end
   end

   jdk_event_gen u_event_gen (
      .x_sample (x_ff),
      .y_sample (y_ff),
      .cfg      (cfg_ff),
      .v_level  (v_level_ff),
      .h_level  (h_level_ff),
      .batch    (batch_next)
   );

   assign cur_ev            = batch_ff.evs[idx_ff];
   assign rsp_chan.valid    = buf_valid_ff;
   assign rsp_chan.kind     = cur_ev.kind;
   assign rsp_chan.key      = cur_ev.key;
   assign rsp_chan.key_set  = cur_ev.key_set;
   assign rsp_chan.axis_x   = cur_ev.axis_x;
   assign rsp_chan.axis_y   = cur_ev.axis_y;
   assign rsp_chan.last     = rsp_is_last;

   `JDK_ASSERT_IMP(a_buf_index, clock, reset, buf_valid_ff,
                   batch_ff.count != 3'd0 && {1'b0, idx_ff} < batch_ff.count)
   `JDK_ASSERT_IMP(a_load_free, clock, reset, load, !buf_valid_ff || drain)
   `JDK_ASSERT_NXT(a_level_hold, clock, reset, !load,
                   $stable(v_level_ff) && $stable(h_level_ff))
   `JDK_ASSERT_NXT(a_sample_hold, clock, reset, in_valid_ff && !load, in_valid_ff)

endmodule
